FILE: sv/ray_quad_intersection_defines.svh
// Assertion macros for the ray/quad intersection block.
// No dependencies; included by the top level.
`ifndef RAY_QUAD_INTERSECTION_DEFINES_SVH
`define RAY_QUAD_INTERSECTION_DEFINES_SVH
`ifndef SYNTHESIS
`define RQI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define RQI_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define RQI_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define RQI_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

FILE: sv/rqi_pkg.sv
// Shared types, widths and latency constants of the ray/quad intersection block.
// No dependencies.
package rqi_pkg;

  localparam int COORD_WIDTH = 20;
  localparam int DIR_WIDTH   = 20;
  localparam int T_WIDTH     = 32;
  localparam int FRAC_SHIFT  = 24;
  localparam int CFG_W       = 3 * COORD_WIDTH;
  localparam int CFG_IDX_W   = 2;

  // datapath widths
  localparam int DW  = COORD_WIDTH + 1;           // corner/origin differences
  localparam int MW  = DW + DIR_WIDTH + 1;        // m cofactors
  localparam int NW  = 2 * DW + 1;                // n cofactors
  localparam int OPA = (DW > DIR_WIDTH) ? DW : DIR_WIDTH;
  localparam int OPB = (MW > NW) ? MW : NW;
  localparam int SW  = OPA + OPB + 3;             // det, tn, gn, bn
  localparam int TSW = SW + FRAC_SHIFT;           // scaled t numerator
  localparam int BW  = T_WIDTH + SW;              // t bound products
  localparam int RW  = SW + 1;                    // divider remainder
  localparam int QW  = T_WIDTH;                   // quotient bits

  localparam int MUL_CHUNK = 24;

  localparam int TRI_LAT = 11;
  localparam int LATENCY = 1 + TRI_LAT + 1 + QW + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CORNER_ZERO  = 2'd0,
    CFG_CORNER_ONE   = 2'd1,
    CFG_CORNER_TWO   = 2'd2,
    CFG_CORNER_THREE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] z;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] x;
  } point_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] origin_x;
    logic signed [COORD_WIDTH-1:0] origin_y;
    logic signed [COORD_WIDTH-1:0] origin_z;
    logic signed [DIR_WIDTH-1:0]   dir_x;
    logic signed [DIR_WIDTH-1:0]   dir_y;
    logic signed [DIR_WIDTH-1:0]   dir_z;
    logic signed [T_WIDTH-1:0]     t_min;
    logic signed [T_WIDTH-1:0]     t_max;
  } ray_t;

  typedef struct packed {
    logic                      hit;
    logic signed [T_WIDTH-1:0] hit_distance;
    logic                      which_face;
  } quad_hit_t;

  typedef struct packed {
    logic                  pass;
    logic signed [TSW-1:0] ts;
    logic signed [SW-1:0]  det;
  } face_res_t;

  typedef struct packed {
    logic valid;
    logic hit;
    logic face;
    logic tneg;
  } div_meta_t;

endpackage

FILE: sv/rqi_mul.sv
// Two-stage signed multiplier: B is cut into chunks, partial products in
// stage one, shifted sum in stage two. Depends on rqi_pkg.
module rqi_mul #(
  parameter int AW = 21,
  parameter int BW = 42
) (
  input  logic                    clk,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int CW  = rqi_pkg::MUL_CHUNK;
  localparam int NC  = (BW + CW - 1) / CW;
  localparam int PPW = AW + CW + 1;

  logic signed [PPW-1:0]   pp [NC];
  logic signed [AW+BW-1:0] acc;

  for (genvar k = 0; k < NC; k++) begin : g_pp
    logic signed [CW:0] op;
    if (k == NC - 1) begin : g_top
      assign op = (CW+1)'($signed(b[BW-1:k*CW]));
    end else begin : g_low
      assign op = {1'b0, b[k*CW +: CW]};
    end
    always_ff @(posedge clk) begin
      pp[k] <= a * op;
    end
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < NC; k++) begin
      acc = acc + ((AW+BW)'(pp[k]) <<< (k * CW));
    end
  end

  always_ff @(posedge clk) begin
    p <= acc;
  end

endmodule

FILE: sv/rqi_tri.sv
// Triangle test pipeline: Cramer cofactors, determinant, sign normalization
// and range checks on t, gamma, beta. Depends on rqi_pkg, rqi_mul.
module rqi_tri (
  input  logic               clk,
  input  rqi_pkg::point_t    p0,
  input  rqi_pkg::point_t    p1,
  input  rqi_pkg::point_t    p2,
  input  rqi_pkg::ray_t      ray,
  output rqi_pkg::face_res_t res
);

  localparam int DW  = rqi_pkg::DW;
  localparam int DRW = rqi_pkg::DIR_WIDTH;
  localparam int MW  = rqi_pkg::MW;
  localparam int NW  = rqi_pkg::NW;
  localparam int SW  = rqi_pkg::SW;
  localparam int TSW = rqi_pkg::TSW;
  localparam int BW  = rqi_pkg::BW;
  localparam int TW  = rqi_pkg::T_WIDTH;

  typedef struct packed {
    logic signed [DW-1:0]  a, b, c, d, e, f, j, k, l;
    logic signed [DRW-1:0] g, h, i;
  } diff_t;

  diff_t                 dq;
  diff_t                 dd [3];
  logic signed [TW-1:0]  tmin_d [8];
  logic signed [TW-1:0]  tmax_d [8];

  // stage 1: differences
  always_ff @(posedge clk) begin
    dq.a <= DW'(p0.x) - DW'(p1.x);
    dq.b <= DW'(p0.y) - DW'(p1.y);
    dq.c <= DW'(p0.z) - DW'(p1.z);
    dq.d <= DW'(p0.x) - DW'(p2.x);
    dq.e <= DW'(p0.y) - DW'(p2.y);
    dq.f <= DW'(p0.z) - DW'(p2.z);
    dq.j <= DW'(p0.x) - DW'(ray.origin_x);
    dq.k <= DW'(p0.y) - DW'(ray.origin_y);
    dq.l <= DW'(p0.z) - DW'(ray.origin_z);
    dq.g <= ray.dir_x;
    dq.h <= ray.dir_y;
    dq.i <= ray.dir_z;
    tmin_d[0] <= ray.t_min;
    tmax_d[0] <= ray.t_max;
    dd[0] <= dq;
    dd[1] <= dd[0];
    dd[2] <= dd[1];
    for (int s = 1; s < 8; s++) begin
      tmin_d[s] <= tmin_d[s-1];
      tmax_d[s] <= tmax_d[s-1];
    end
  end

  // stages 2-4: m = cross(e/f/d, dir), n = cross(a/b/c, j/k/l)
  logic signed [DRW-1:0]    m_ax [3], m_ay [3];
  logic signed [DW-1:0]     m_bx [3], m_by [3];
  logic signed [DRW+DW-1:0] m_px [3], m_py [3];
  logic signed [DW-1:0]     n_ax [3], n_ay [3], n_bx [3], n_by [3];
  logic signed [2*DW-1:0]   n_px [3], n_py [3];
  logic signed [MW-1:0]     m_q [3];
  logic signed [NW-1:0]     n_q [3];

  assign m_ax[0] = dq.i;  assign m_bx[0] = dq.e;  assign m_ay[0] = dq.h;  assign m_by[0] = dq.f;
  assign m_ax[1] = dq.g;  assign m_bx[1] = dq.f;  assign m_ay[1] = dq.i;  assign m_by[1] = dq.d;
  assign m_ax[2] = dq.h;  assign m_bx[2] = dq.d;  assign m_ay[2] = dq.g;  assign m_by[2] = dq.e;
  assign n_ax[0] = dq.a;  assign n_bx[0] = dq.k;  assign n_ay[0] = dq.j;  assign n_by[0] = dq.b;
  assign n_ax[1] = dq.j;  assign n_bx[1] = dq.c;  assign n_ay[1] = dq.a;  assign n_by[1] = dq.l;
  assign n_ax[2] = dq.b;  assign n_bx[2] = dq.l;  assign n_ay[2] = dq.k;  assign n_by[2] = dq.c;

  for (genvar q = 0; q < 3; q++) begin : g_mn
    rqi_mul #(.AW(DRW), .BW(DW)) u_mx (.clk(clk), .a(m_ax[q]), .b(m_bx[q]), .p(m_px[q]));
    rqi_mul #(.AW(DRW), .BW(DW)) u_my (.clk(clk), .a(m_ay[q]), .b(m_by[q]), .p(m_py[q]));
    rqi_mul #(.AW(DW), .BW(DW))  u_nx (.clk(clk), .a(n_ax[q]), .b(n_bx[q]), .p(n_px[q]));
    rqi_mul #(.AW(DW), .BW(DW))  u_ny (.clk(clk), .a(n_ay[q]), .b(n_by[q]), .p(n_py[q]));
    always_ff @(posedge clk) begin
      m_q[q] <= MW'(m_px[q]) - MW'(m_py[q]);
      n_q[q] <= NW'(n_px[q]) - NW'(n_py[q]);
    end
  end

  // stages 5-7: det, tn, gn, bn
  logic signed [DW-1:0]     det_a [3], tn_a [3], bn_a [3];
  logic signed [DRW-1:0]    gn_a [3];
  logic signed [DW+MW-1:0]  det_p [3], bn_p [3];
  logic signed [DW+NW-1:0]  tn_p [3];
  logic signed [DRW+NW-1:0] gn_p [3];
  logic signed [SW-1:0]     det_s, tn_s, gn_s, bn_s;

  assign det_a[0] = dd[2].a;  assign det_a[1] = dd[2].b;  assign det_a[2] = dd[2].c;
  assign tn_a[0]  = dd[2].f;  assign tn_a[1]  = dd[2].e;  assign tn_a[2]  = dd[2].d;
  assign gn_a[0]  = dd[2].i;  assign gn_a[1]  = dd[2].h;  assign gn_a[2]  = dd[2].g;
  assign bn_a[0]  = dd[2].j;  assign bn_a[1]  = dd[2].k;  assign bn_a[2]  = dd[2].l;

  for (genvar q = 0; q < 3; q++) begin : g_cr
    rqi_mul #(.AW(DW), .BW(MW))  u_det (.clk(clk), .a(det_a[q]), .b(m_q[q]), .p(det_p[q]));
    rqi_mul #(.AW(DW), .BW(NW))  u_tn  (.clk(clk), .a(tn_a[q]),  .b(n_q[q]), .p(tn_p[q]));
    rqi_mul #(.AW(DRW), .BW(NW)) u_gn  (.clk(clk), .a(gn_a[q]),  .b(n_q[q]), .p(gn_p[q]));
    rqi_mul #(.AW(DW), .BW(MW))  u_bn  (.clk(clk), .a(bn_a[q]),  .b(m_q[q]), .p(bn_p[q]));
  end

  always_ff @(posedge clk) begin
    det_s <= SW'(det_p[0]) + SW'(det_p[1]) + SW'(det_p[2]);
    tn_s  <= -(SW'(tn_p[0]) + SW'(tn_p[1]) + SW'(tn_p[2]));
    gn_s  <= SW'(gn_p[0]) + SW'(gn_p[1]) + SW'(gn_p[2]);
    bn_s  <= SW'(bn_p[0]) + SW'(bn_p[1]) + SW'(bn_p[2]);
  end

  // stage 8: make det positive, scale t numerator
  logic signed [SW-1:0]  det_n, gn_n, bn_n;
  logic signed [TSW-1:0] ts_n;
  logic                  nz;
  logic                  neg;

  assign neg = det_s[SW-1];

  always_ff @(posedge clk) begin
    det_n <= neg ? -det_s : det_s;
    gn_n  <= neg ? -gn_s : gn_s;
    bn_n  <= neg ? -bn_s : bn_s;
    ts_n  <= TSW'(neg ? -tn_s : tn_s) <<< rqi_pkg::FRAC_SHIFT;
    nz    <= (det_s != '0);
  end

  // stages 9-11: barycentric flags, t bounds
  logic                  flag9, flag10;
  logic signed [TSW-1:0] ts_d [2];
  logic signed [SW-1:0]  det_d [2];
  logic signed [BW-1:0]  lo_p, hi_p;

  rqi_mul #(.AW(TW), .BW(SW)) u_lo (.clk(clk), .a(tmin_d[7]), .b(det_n), .p(lo_p));
  rqi_mul #(.AW(TW), .BW(SW)) u_hi (.clk(clk), .a(tmax_d[7]), .b(det_n), .p(hi_p));

  always_ff @(posedge clk) begin
    flag9 <= nz && !gn_n[SW-1] && (gn_n <= det_n) && !bn_n[SW-1]
             && (((SW+1)'(bn_n) + (SW+1)'(gn_n)) <= (SW+1)'(det_n));
    flag10   <= flag9;
    ts_d[0]  <= ts_n;
    ts_d[1]  <= ts_d[0];
    det_d[0] <= det_n;
    det_d[1] <= det_d[0];
    res.pass <= flag10 && (lo_p <= BW'(ts_d[1])) && (BW'(ts_d[1]) <= hi_p);
    res.ts   <= ts_d[1];
    res.det  <= det_d[1];
  end

endmodule

FILE: sv/rqi_div.sv
// Pipelined restoring divider, one quotient bit per stage; side data travels
// alongside. Depends on rqi_pkg.
module rqi_div (
  input  logic                         clk,
  input  logic                         rst,
  input  rqi_pkg::div_meta_t           in_meta,
  input  logic [rqi_pkg::TSW-1:0]      num,
  input  logic [rqi_pkg::SW-1:0]       den,
  output rqi_pkg::div_meta_t           out_meta,
  output logic [rqi_pkg::QW-1:0]       quo
);

  localparam int QW  = rqi_pkg::QW;
  localparam int RW  = rqi_pkg::RW;
  localparam int SW  = rqi_pkg::SW;
  localparam int TSW = rqi_pkg::TSW;

  logic [RW-1:0]      rem  [QW];
  logic [QW-1:0]      quot [QW];
  logic [QW-1:0]      low  [QW];
  logic [SW-1:0]      dv   [QW];
  rqi_pkg::div_meta_t meta [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [RW-1:0]      r_prev, trial;
    logic [QW-1:0]      q_prev, l_prev;
    logic [SW-1:0]      d_prev;
    rqi_pkg::div_meta_t m_prev;
    logic               ge;

    if (k == 0) begin : g_first
      // quotient fits QW bits, so the upper part of num is already below den
      assign r_prev = RW'(num[TSW-1:QW]);
      assign l_prev = num[QW-1:0];
      assign q_prev = '0;
      assign d_prev = den;
      assign m_prev = in_meta;
    end else begin : g_next
      assign r_prev = rem[k-1];
      assign l_prev = low[k-1];
      assign q_prev = quot[k-1];
      assign d_prev = dv[k-1];
      assign m_prev = meta[k-1];
    end

    assign trial = {r_prev[RW-2:0], l_prev[QW-1]};
    assign ge    = (trial >= RW'(d_prev));

    always_ff @(posedge clk) begin
      if (rst) begin
        meta[k] <= '0;
      end else begin
        meta[k] <= m_prev;
      end
    end

    always_ff @(posedge clk) begin
      rem[k]  <= ge ? (trial - RW'(d_prev)) : trial;
      quot[k] <= {q_prev[QW-2:0], ge};
      low[k]  <= {l_prev[QW-2:0], 1'b0};
      dv[k]   <= d_prev;
    end
  end

  assign quo      = quot[QW-1];
  assign out_meta = meta[QW-1];

endmodule

FILE: sv/ray_quad_intersection.sv
// Top level of the ray/quad intersection block: corner registers, two
// triangle pipelines, face select, divider and result register.
// Depends on rqi_pkg, rqi_tri, rqi_div and ray_quad_intersection_defines.svh.
//
// Usage:
//   Ray channel: drive ray and raise start; the ray transaction is taken at
//   every rising edge with start high (busy is always low, so a new ray may
//   enter every cycle). Throughput is one ray per clock.
//   Result channel: done pulses for one cycle with result valid; the
//   receiver cannot stall, so each result must be taken in that cycle.
//   Pipeline from the accepting edge to the ports: input register, 11
//   stages of triangle test, face select, 32 divider stages (one quotient
//   bit each), output register.
//   Configuration: cfg_we with cfg_index 0..3 writes corner 0..3 (packed
//   z,y,x, signed Q12.8). Write only while no ray is in flight.
//   Reset (rst, synchronous): clears corners to zero and all valid bits;
//   rays in flight are dropped. No clearing pass; ready right after reset.
//   Face 0 (c0,c1,c2) is preferred; face 1 (c0,c2,c3) counts only when
//   face 0 misses. A miss reports zero distance and face 0.
`include "ray_quad_intersection_defines.svh"

module ray_quad_intersection (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  rqi_pkg::ray_t                     ray,
  output logic                              done,
  output rqi_pkg::quad_hit_t                result,
  input  logic                              cfg_we,
  input  logic [rqi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rqi_pkg::CFG_W-1:0]         cfg_data
);

  localparam int TRI_LAT = rqi_pkg::TRI_LAT;
  localparam int TSW     = rqi_pkg::TSW;
  localparam int SW      = rqi_pkg::SW;
  localparam int QW      = rqi_pkg::QW;
  localparam int RW      = rqi_pkg::RW;
  localparam int TW      = rqi_pkg::T_WIDTH;

  // never blocks: fully pipelined
  assign busy = 1'b0;

  // corner registers
  logic [rqi_pkg::CFG_W-1:0] corner_zero, corner_one, corner_two, corner_three;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_zero  <= '0;
      corner_one   <= '0;
      corner_two   <= '0;
      corner_three <= '0;
    end else if (cfg_we) begin
      unique case (rqi_pkg::cfg_reg_t'(cfg_index))
        rqi_pkg::CFG_CORNER_ZERO:  corner_zero  <= cfg_data;
        rqi_pkg::CFG_CORNER_ONE:   corner_one   <= cfg_data;
        rqi_pkg::CFG_CORNER_TWO:   corner_two   <= cfg_data;
        rqi_pkg::CFG_CORNER_THREE: corner_three <= cfg_data;
        default: ;
      endcase
    end
  end

  rqi_pkg::point_t c0, c1, c2, c3;
  assign c0 = rqi_pkg::point_t'(corner_zero);
  assign c1 = rqi_pkg::point_t'(corner_one);
  assign c2 = rqi_pkg::point_t'(corner_two);
  assign c3 = rqi_pkg::point_t'(corner_three);

  // input register
  logic          accept;
  logic          in_v;
  rqi_pkg::ray_t ray_q;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else begin
      in_v <= accept;
    end
  end

  always_ff @(posedge clk) begin
    ray_q <= ray;
  end

  // both triangles in parallel
  rqi_pkg::face_res_t res0, res1;

  rqi_tri u_face0 (.clk(clk), .p0(c0), .p1(c1), .p2(c2), .ray(ray_q), .res(res0));
  rqi_tri u_face1 (.clk(clk), .p0(c0), .p1(c2), .p2(c3), .ray(ray_q), .res(res1));

  // valid bits alongside the triangle pipelines
  logic [TRI_LAT-1:0] tri_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      tri_v <= '0;
    end else begin
      tri_v <= {tri_v[TRI_LAT-2:0], in_v};
    end
  end

  // face select, sign split for the divider
  rqi_pkg::div_meta_t    sel_meta, sel_meta_next;
  logic [TSW-1:0]        sel_mag, sel_mag_next;
  logic [SW-1:0]         sel_det, sel_det_next;
  logic signed [TSW-1:0] ts_pick;

  always_comb begin
    ts_pick             = res0.pass ? res0.ts : res1.ts;
    sel_det_next        = res0.pass ? res0.det : res1.det;
    sel_meta_next.valid = tri_v[TRI_LAT-1];
    sel_meta_next.hit   = res0.pass || res1.pass;
    sel_meta_next.face  = !res0.pass && res1.pass;
    sel_meta_next.tneg  = ts_pick[TSW-1];
    sel_mag_next        = ts_pick[TSW-1] ? -ts_pick : ts_pick;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_meta <= '0;
    end else begin
      sel_meta <= sel_meta_next;
    end
  end

  always_ff @(posedge clk) begin
    sel_mag <= sel_mag_next;
    sel_det <= sel_det_next;
  end

  // t = |ts| / det, one bit per stage
  rqi_pkg::div_meta_t div_meta;
  logic [QW-1:0]      quo;

  rqi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_meta  (sel_meta),
    .num      (sel_mag),
    .den      (sel_det),
    .out_meta (div_meta),
    .quo      (quo)
  );

  // output register
  logic [TW-1:0] t_signed;
  assign t_signed = div_meta.tneg ? -quo : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_meta.valid;
    end
  end

  always_ff @(posedge clk) begin
    result.hit          <= div_meta.hit;
    result.hit_distance <= div_meta.hit ? t_signed : '0;
    result.which_face   <= div_meta.hit && div_meta.face;
  end

  // checks
  logic [RW-1:0] div_head;
  assign div_head = RW'(sel_mag[TSW-1:QW]);

  `RQI_ASSERT_IMPLY(a_latency, clk, rst, done, $past(accept, rqi_pkg::LATENCY))
  `RQI_ASSERT_IMPLY(a_miss_zero, clk, rst, done && !result.hit, result.hit_distance == '0 && !result.which_face)
  `RQI_ASSERT_IMPLY(a_div_range, clk, rst, sel_meta.valid && sel_meta.hit, div_head < RW'(sel_det))
  `RQI_ASSERT_NEVER(a_zero_det_hit, clk, rst, sel_meta.valid && sel_meta.hit && sel_det == '0)

endmodule
